/* hdl/eik8_pkg.sv */
package eik8_pkg;

	localparam int VW = 32;
	localparam logic [VW-1:0] INF = '1;
	localparam int SPD_W = 16;
	localparam int SH_QW = VW + 8;
	localparam int A_QW = 30;
	localparam int RW = 31;

	localparam logic [30:0] Q30 = 31'h4000_0000;
	localparam logic [31:0] TWO_Q30 = 32'h8000_0000;
	localparam logic [63:0] HALF = 64'h0000_0000_2000_0000;
	localparam logic [30:0] C_R2 = 31'd1518500250;
	localparam logic [29:0] C_R2H = 30'd759250125;
	localparam logic [30:0] C_R3 = 31'd1859775393;

	localparam int NPAIR = 12;
	localparam int NDIAG = 8;
	localparam int NCAND = 20;
	localparam int PAIR_I0 [NPAIR] = '{0, 2, 4, 6, 2, 4, 6, 0, 0, 2, 4, 6};
	localparam int PAIR_I1 [NPAIR] = '{1, 3, 5, 7, 1, 3, 5, 7, 2, 4, 6, 0};

	// stage times after the step size is known
	localparam int T_P1 = 1;
	localparam int T_Q1 = T_P1 + A_QW;
	localparam int T_A2 = T_Q1 + 2;
	localparam int T_R1 = T_A2 + RW;
	localparam int T_Q2 = T_R1 + RW;
	localparam int T_LAM = T_Q2 + 1;
	localparam int T_R2 = T_LAM + 1 + RW;
	localparam int T_B2 = T_R2 + 2;
	localparam int T_B3 = T_B2 + 1;
	localparam int T_BEST = T_B3 + 3;

	typedef struct packed {
		logic [7:0][VW-1:0] u;
		logic [7:0]         mask;
		logic [VW-1:0]      cur;
	} itm_t;

	typedef struct packed {
		itm_t          itm;
		logic [VW-1:0] sh;
		logic [VW:0]   oned;
	} glb_t;

	function automatic logic [VW-1:0] vmin(input logic [VW-1:0] a, input logic [VW-1:0] b);
		return (a < b) ? a : b;
	endfunction

endpackage

/* hdl/eik8_div.sv */
module eik8_div #(
	parameter int DW = 32,
	parameter int QW = 30
) (
	input  logic          clk,
	input  logic [DW-1:0] num_hi,
	input  logic [QW-1:0] num_lo,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	logic [DW-1:0] rem_s  [QW];
	logic [DW-1:0] den_s  [QW];
	logic [QW-1:0] word_s [QW];

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic [DW-1:0] rem_in;
		logic [DW-1:0] den_in;
		logic [QW-1:0] word_in;
		logic [DW:0]   trial;
		logic          ge;

		if (i == 0) begin : g_first
			assign rem_in  = num_hi;
			assign den_in  = den;
			assign word_in = num_lo;
		end else begin : g_next
			assign rem_in  = rem_s[i-1];
			assign den_in  = den_s[i-1];
			assign word_in = word_s[i-1];
		end

		assign trial = {rem_in, word_in[QW-1]};
		assign ge    = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			rem_s[i]  <= ge ? DW'(trial - {1'b0, den_in}) : DW'(trial);
			den_s[i]  <= den_in;
			word_s[i] <= {word_in[QW-2:0], ge};
		end
	end

	assign quo = word_s[QW-1];

endmodule

/* hdl/eik8_sqrt.sv */
module eik8_sqrt #(
	parameter int RW = 31
) (
	input  logic            clk,
	input  logic [2*RW-1:0] rad,
	output logic [RW-1:0]   root
);

	logic [RW+1:0]   rem_s  [RW];
	logic [RW-1:0]   root_s [RW];
	logic [2*RW-1:0] word_s [RW];

	for (genvar i = 0; i < RW; i++) begin : g_stage
		logic [RW+1:0]   rem_in;
		logic [RW-1:0]   root_in;
		logic [2*RW-1:0] word_in;
		logic [RW+3:0]   trial;
		logic [RW+3:0]   tst;
		logic            ge;

		if (i == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign word_in = rad;
		end else begin : g_next
			assign rem_in  = rem_s[i-1];
			assign root_in = root_s[i-1];
			assign word_in = word_s[i-1];
		end

		assign trial = {rem_in, word_in[2*RW-1:2*RW-2]};
		assign tst   = {2'b00, root_in, 2'b01};
		assign ge    = trial >= tst;

		always_ff @(posedge clk) begin
			rem_s[i]  <= ge ? (RW+2)'(trial - tst) : (RW+2)'(trial);
			root_s[i] <= {root_in[RW-2:0], ge};
			word_s[i] <= {word_in[2*RW-3:0], 2'b00};
		end
	end

	assign root = root_s[RW-1];

endmodule

/* hdl/eikonal_8pt_node_update.sv */
// channel   direction  handshake                 payload
// config    in         cfg_write                 cfg_data (grid spacing)
// node      in         start, accepted if !busy  eight neighbor values, mask, speed, current
// result    out        done, one-cycle strobe    new_value, improved
//
// one item per cycle, busy stays low
// each item passes through the step divider,
// then per pair the alpha divider, two root units and the lambda divider
// reset clears the valid chain and the strobe and sets the spacing register to 65536
// the receiver cannot stall, so the pipeline never holds
module eikonal_8pt_node_update (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [31:0] cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] north_value,
	input  logic [31:0] northeast_value,
	input  logic [31:0] east_value,
	input  logic [31:0] southeast_value,
	input  logic [31:0] south_value,
	input  logic [31:0] southwest_value,
	input  logic [31:0] west_value,
	input  logic [31:0] northwest_value,
	input  logic [7:0]  neighbor_valid,
	input  logic [15:0] local_speed,
	input  logic [31:0] current_value,
	output logic        done,
	output logic [31:0] new_value,
	output logic        improved
);

	localparam int GO = eik8_pkg::SH_QW + 1;
	localparam int NV = GO + eik8_pkg::T_BEST + 1;

	logic [31:0]                  h_q;
	logic                         v_s [NV];
	eik8_pkg::itm_t               itm_s [eik8_pkg::SH_QW+1];
	logic [eik8_pkg::SPD_W-1:0]   spd_s1;
	logic [31:0]                  h_s1;
	logic [eik8_pkg::SH_QW-1:0]   shq;
	logic [31:0]                  sh0;
	logic [63:0]                  oprod;
	eik8_pkg::glb_t               glb_s [eik8_pkg::T_BEST+1];
	logic [31:0]                  pt_s [eik8_pkg::NPAIR];
	logic [31:0]                  cand_s [eik8_pkg::NCAND];
	logic [31:0]                  grp_s [5];
	logic [31:0]                  best_s;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= 32'd65536;
		end else if (cfg_write) begin
			h_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NV; i++) v_s[i] <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s[0] <= start;
			for (int i = 1; i < NV; i++) v_s[i] <= v_s[i-1];
			done <= v_s[NV-1];
		end
	end

	always_ff @(posedge clk) begin
		itm_s[0].u <= {northwest_value, west_value, southwest_value, south_value,
			southeast_value, east_value, northeast_value, north_value};
		itm_s[0].mask <= neighbor_valid;
		itm_s[0].cur <= current_value;
		spd_s1 <= local_speed;
		h_s1 <= h_q;
		for (int t = 1; t <= eik8_pkg::SH_QW; t++) itm_s[t] <= itm_s[t-1];
	end

	// step size sh = h * 256 / speed, zero speed gives all ones
	eik8_div #(
		.DW(eik8_pkg::SPD_W),
		.QW(eik8_pkg::SH_QW)
	) u_shdiv (
		.clk   (clk),
		.num_hi(16'd0),
		.num_lo({h_s1, 8'd0}),
		.den   (spd_s1),
		.quo   (shq)
	);

	assign sh0 = (shq >= {8'd0, eik8_pkg::INF}) ? eik8_pkg::INF : shq[31:0];
	assign oprod = {32'd0, glb_s[0].sh} * {33'd0, eik8_pkg::C_R2} + eik8_pkg::HALF;

	always_ff @(posedge clk) begin
		glb_s[0].itm <= itm_s[eik8_pkg::SH_QW];
		glb_s[0].sh <= sh0;
		glb_s[0].oned <= '0;
		glb_s[1].itm <= glb_s[0].itm;
		glb_s[1].sh <= glb_s[0].sh;
		glb_s[1].oned <= oprod[62:30];
		for (int t = 2; t <= eik8_pkg::T_BEST; t++) glb_s[t] <= glb_s[t-1];
	end

	for (genvar j = 0; j < eik8_pkg::NPAIR; j++) begin : g_pair
		localparam bit DIAG = (j < eik8_pkg::NDIAG);
		localparam logic [2:0] I0 = 3'(eik8_pkg::PAIR_I0[j]);
		localparam logic [2:0] I1 = 3'(eik8_pkg::PAIR_I1[j]);

		logic [31:0] u0_0;
		logic [31:0] u1_0;
		logic [31:0] dif_s;
		logic [61:0] prd_s;
		logic        bad_s;
		logic        fail_s [eik8_pkg::T_P1+1:eik8_pkg::T_B2];
		logic        dz_s [eik8_pkg::T_P1+1:eik8_pkg::T_Q1];
		logic [29:0] q1;
		logic [29:0] a_s;
		logic [59:0] asq;
		logic [60:0] r3a;
		logic [29:0] a2_s;
		logic [30:0] nv_s [eik8_pkg::T_A2:eik8_pkg::T_R1];
		logic [31:0] x1;
		logic [30:0] root1;
		logic [30:0] q2;
		logic [30:0] lam_s [eik8_pkg::T_LAM:eik8_pkg::T_R2];
		logic [61:0] lsq;
		logic [61:0] lp;
		logic [31:0] x2_s;
		logic [30:0] root2;
		logic [63:0] m0_s;
		logic [63:0] m1_s;
		logic [63:0] mc_s;
		logic [63:0] msum;
		logic [63:0] csum;
		logic [31:0] mix_s;
		logic [33:0] cost_s;
		logic [34:0] tot;

		assign u0_0 = glb_s[0].itm.u[I0];
		assign u1_0 = glb_s[0].itm.u[I1];

		always_ff @(posedge clk) begin
			dif_s <= (u0_0 > u1_0) ? u0_0 - u1_0 : u1_0 - u0_0;
			prd_s <= {30'd0, glb_s[0].sh} * {32'd0, eik8_pkg::C_R2H};
			bad_s <= (u0_0 == eik8_pkg::INF) || (u1_0 == eik8_pkg::INF) ||
				(glb_s[0].sh == eik8_pkg::INF);
		end

		always_ff @(posedge clk) begin
			fail_s[eik8_pkg::T_P1+1] <= bad_s || ({dif_s, 30'd0} > prd_s);
			dz_s[eik8_pkg::T_P1+1] <= (dif_s == 32'd0);
			for (int t = eik8_pkg::T_P1 + 2; t <= eik8_pkg::T_B2; t++) fail_s[t] <= fail_s[t-1];
			for (int t = eik8_pkg::T_P1 + 2; t <= eik8_pkg::T_Q1; t++) dz_s[t] <= dz_s[t-1];
		end

		// alpha = d / sh in Q30
		eik8_div #(
			.DW(32),
			.QW(eik8_pkg::A_QW)
		) u_adiv (
			.clk   (clk),
			.num_hi(dif_s),
			.num_lo(30'd0),
			.den   (glb_s[eik8_pkg::T_P1].sh),
			.quo   (q1)
		);

		assign asq = {30'd0, a_s} * {30'd0, a_s};
		assign r3a = {30'd0, eik8_pkg::C_R3} * {31'd0, a_s};

		always_ff @(posedge clk) begin
			a_s <= dz_s[eik8_pkg::T_Q1] ? 30'd0 : q1;
			a2_s <= asq[59:30];
			nv_s[eik8_pkg::T_A2] <= DIAG ? {1'b0, a_s} : r3a[60:30];
			for (int t = eik8_pkg::T_A2 + 1; t <= eik8_pkg::T_R1; t++) nv_s[t] <= nv_s[t-1];
		end

		assign x1 = DIAG ? ({1'b0, eik8_pkg::Q30} - {2'b00, a2_s})
			: ({2'b00, a2_s} + eik8_pkg::TWO_Q30);

		eik8_sqrt #(
			.RW(eik8_pkg::RW)
		) u_sq1 (
			.clk (clk),
			.rad ({x1, 30'd0}),
			.root(root1)
		);

		eik8_div #(
			.DW(eik8_pkg::RW),
			.QW(eik8_pkg::RW)
		) u_ldiv (
			.clk   (clk),
			.num_hi({1'b0, nv_s[eik8_pkg::T_R1][30:1]}),
			.num_lo({nv_s[eik8_pkg::T_R1][0], 30'd0}),
			.den   (root1),
			.quo   (q2)
		);

		assign lsq = {31'd0, lam_s[eik8_pkg::T_LAM]} * {31'd0, lam_s[eik8_pkg::T_LAM]};
		assign lp = {31'd0, lam_s[eik8_pkg::T_LAM]} *
			{31'd0, eik8_pkg::Q30 - lam_s[eik8_pkg::T_LAM]};

		always_ff @(posedge clk) begin
			lam_s[eik8_pkg::T_LAM] <= DIAG ? ((q2 > eik8_pkg::Q30) ? eik8_pkg::Q30 : q2)
				: 31'(({1'b0, eik8_pkg::Q30} + {1'b0, q2}) >> 1);
			for (int t = eik8_pkg::T_LAM + 1; t <= eik8_pkg::T_R2; t++) lam_s[t] <= lam_s[t-1];
			x2_s <= DIAG ? ({1'b0, eik8_pkg::Q30} + lsq[61:30])
				: ({1'b0, eik8_pkg::Q30} + {lp[60:30], 1'b0});
		end

		eik8_sqrt #(
			.RW(eik8_pkg::RW)
		) u_sq2 (
			.clk (clk),
			.rad ({x2_s, 30'd0}),
			.root(root2)
		);

		assign msum = m0_s + m1_s + eik8_pkg::HALF;
		assign csum = mc_s + eik8_pkg::HALF;
		assign tot = {3'd0, mix_s} + {1'b0, cost_s};

		always_ff @(posedge clk) begin
			m0_s <= {32'd0, glb_s[eik8_pkg::T_R2].itm.u[I0]} *
				{33'd0, eik8_pkg::Q30 - lam_s[eik8_pkg::T_R2]};
			m1_s <= {32'd0, glb_s[eik8_pkg::T_R2].itm.u[I1]} * {33'd0, lam_s[eik8_pkg::T_R2]};
			mc_s <= {32'd0, glb_s[eik8_pkg::T_R2].sh} * {33'd0, root2};
			mix_s <= msum[61:30];
			cost_s <= csum[63:30];
			pt_s[j] <= (fail_s[eik8_pkg::T_B2] || tot >= {3'd0, eik8_pkg::INF}) ?
				eik8_pkg::INF : tot[31:0];
			cand_s[8+j] <= (glb_s[eik8_pkg::T_B3].itm.mask[I0] &&
				glb_s[eik8_pkg::T_B3].itm.mask[I1]) ? pt_s[j] : eik8_pkg::INF;
		end
	end

	for (genvar k = 0; k < 8; k++) begin : g_one
		localparam logic [2:0] KP1 = 3'(k + 1);
		localparam logic [2:0] KP2 = 3'(k + 2);
		localparam logic [2:0] KM1 = 3'(k + 7);
		localparam logic [2:0] KM2 = 3'(k + 6);

		logic [7:0]  m;
		logic        en;
		logic [33:0] sum;

		assign m = glb_s[eik8_pkg::T_B3].itm.mask;

		if ((k % 2) == 0) begin : g_axis
			assign en = m[k] & ~m[KM2] & ~m[KM1] & ~m[KP1] & ~m[KP2];
			assign sum = {2'b00, glb_s[eik8_pkg::T_B3].itm.u[k]} +
				{2'b00, glb_s[eik8_pkg::T_B3].sh};
		end else begin : g_diag
			assign en = m[k] & ~m[KM1] & ~m[KP1];
			assign sum = {2'b00, glb_s[eik8_pkg::T_B3].itm.u[k]} +
				{1'b0, glb_s[eik8_pkg::T_B3].oned};
		end

		always_ff @(posedge clk) begin
			cand_s[k] <= (!en || sum >= {2'b00, eik8_pkg::INF}) ? eik8_pkg::INF : sum[31:0];
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < 5; g++) begin
			grp_s[g] <= eik8_pkg::vmin(eik8_pkg::vmin(cand_s[4*g], cand_s[4*g+1]),
				eik8_pkg::vmin(cand_s[4*g+2], cand_s[4*g+3]));
		end
		best_s <= eik8_pkg::vmin(eik8_pkg::vmin(eik8_pkg::vmin(grp_s[0], grp_s[1]),
			eik8_pkg::vmin(grp_s[2], grp_s[3])), grp_s[4]);
		new_value <= best_s;
		improved <= (best_s <= glb_s[eik8_pkg::T_BEST].itm.cur);
	end

endmodule

/* test/eik8_node_checker.sv */
`timescale 1ns / 1ps

module eik8_node_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [31:0] cfg_data,
	input  logic        start,
	input  logic        busy,
	input  logic [31:0] north_value,
	input  logic [31:0] northeast_value,
	input  logic [31:0] east_value,
	input  logic [31:0] southeast_value,
	input  logic [31:0] south_value,
	input  logic [31:0] southwest_value,
	input  logic [31:0] west_value,
	input  logic [31:0] northwest_value,
	input  logic [7:0]  neighbor_valid,
	input  logic [15:0] local_speed,
	input  logic [31:0] current_value,
	input  logic        done,
	input  logic [31:0] new_value,
	input  logic        improved,
	output int          mismatches,
	output int          outstanding
);

	localparam bit [63:0] VINF = 64'hFFFF_FFFF;
	localparam bit [63:0] ONE30 = 64'h4000_0000;
	localparam bit [63:0] K_R2 = 64'd1518500250;
	localparam bit [63:0] K_R2H = 64'd759250125;
	localparam bit [63:0] K_R3 = 64'd1859775393;

	typedef struct {
		logic [31:0] value;
		logic        better;
	} update_t;

	update_t     pending_updates[$];
	logic [31:0] spacing;

	function automatic bit [63:0] int_sqrt(input bit [63:0] x);
		bit [63:0] r;
		bit [63:0] b;
		bit [63:0] v;
		v = x;
		r = 0;
		b = 64'h1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic bit [63:0] round30(input bit [63:0] x);
		return (x + (64'h1 << 29)) >> 30;
	endfunction

	function automatic bit [63:0] clip_inf(input bit [63:0] x);
		return (x >= VINF) ? VINF : x;
	endfunction

	function automatic bit [63:0] mix_cost(input bit [63:0] u0, input bit [63:0] u1,
			input bit [63:0] lam, input bit [63:0] sh, input bit [63:0] root);
		return clip_inf(round30(u0 * (ONE30 - lam) + u1 * lam) + round30(sh * root));
	endfunction

	// returns 0 when the slope is too steep for a two-point update
	function automatic bit slope_ok(input bit [63:0] u0, input bit [63:0] u1,
			input bit [63:0] sh, output bit [63:0] alpha);
		bit [63:0] d;
		d = (u0 > u1) ? u0 - u1 : u1 - u0;
		alpha = 0;
		if ((d << 30) > sh * K_R2H)
			return 0;
		alpha = (d == 0) ? 0 : (d << 30) / sh;
		return 1;
	endfunction

	function automatic bit [63:0] diag_pair(input bit [63:0] u0, input bit [63:0] u1,
			input bit [63:0] sh);
		bit [63:0] a;
		bit [63:0] s;
		bit [63:0] lam;
		bit [63:0] l2;
		if (u0 == VINF || u1 == VINF || sh == VINF)
			return VINF;
		if (!slope_ok(u0, u1, sh, a))
			return VINF;
		s = int_sqrt((ONE30 - ((a * a) >> 30)) << 30);
		lam = (a << 30) / s;
		if (lam > ONE30)
			lam = ONE30;
		l2 = (lam * lam) >> 30;
		return mix_cost(u0, u1, lam, sh, int_sqrt((ONE30 + l2) << 30));
	endfunction

	function automatic bit [63:0] axis_pair(input bit [63:0] u0, input bit [63:0] u1,
			input bit [63:0] sh);
		bit [63:0] a;
		bit [63:0] num;
		bit [63:0] den;
		bit [63:0] lam;
		bit [63:0] p;
		if (u0 == VINF || u1 == VINF || sh == VINF)
			return VINF;
		if (!slope_ok(u0, u1, sh, a))
			return VINF;
		num = (K_R3 * a) >> 30;
		den = int_sqrt((((a * a) >> 30) + 2 * ONE30) << 30);
		lam = (ONE30 + (num << 30) / den) >> 1;
		p = (lam * (ONE30 - lam)) >> 30;
		return mix_cost(u0, u1, lam, sh, int_sqrt((ONE30 + 2 * p) << 30));
	endfunction

	function automatic update_t node_update(input bit [63:0] u[8], input logic [7:0] m,
			input logic [15:0] speed, input logic [31:0] cur, input logic [31:0] h);
		bit [63:0] sh;
		bit [63:0] best;
		bit [63:0] c;
		update_t   res;
		best = VINF;
		if (speed == 0)
			sh = VINF;
		else
			sh = clip_inf((64'(h) << 8) / speed);
		for (int k = 0; k < 8; k += 2) begin
			if (m[k] && !m[(k+6)%8] && !m[(k+7)%8] && !m[(k+1)%8] && !m[(k+2)%8]) begin
				c = (u[k] == VINF) ? VINF : clip_inf(u[k] + sh);
				if (c < best) best = c;
			end
		end
		for (int k = 1; k < 8; k += 2) begin
			if (m[k] && !m[(k+7)%8] && !m[(k+1)%8]) begin
				c = (u[k] == VINF) ? VINF : clip_inf(u[k] + round30(sh * K_R2));
				if (c < best) best = c;
			end
		end
		for (int k = 0; k < 8; k += 2) begin
			if (m[k] && m[k+1]) begin
				c = diag_pair(u[k], u[k+1], sh);
				if (c < best) best = c;
			end
		end
		for (int k = 1; k < 8; k += 2) begin
			if (m[(k+1)%8] && m[k]) begin
				c = diag_pair(u[(k+1)%8], u[k], sh);
				if (c < best) best = c;
			end
		end
		for (int k = 0; k < 8; k += 2) begin
			if (m[k] && m[(k+2)%8]) begin
				c = axis_pair(u[k], u[(k+2)%8], sh);
				if (c < best) best = c;
			end
		end
		res.value = best[31:0];
		res.better = (best <= 64'(cur));
		return res;
	endfunction

	assign outstanding = pending_updates.size();

	always @(posedge clk or negedge arst_n) begin
		bit [63:0] nb[8];
		update_t   want;
		if (!arst_n) begin
			spacing = 32'd65536;
			pending_updates.delete();
			mismatches = 0;
		end else begin
			if (start && !busy) begin
				nb[0] = north_value;
				nb[1] = northeast_value;
				nb[2] = east_value;
				nb[3] = southeast_value;
				nb[4] = south_value;
				nb[5] = southwest_value;
				nb[6] = west_value;
				nb[7] = northwest_value;
				pending_updates.push_back(node_update(nb, neighbor_valid, local_speed,
					current_value, spacing));
			end
			if (cfg_write)
				spacing = cfg_data;
			if (done) begin
				if (pending_updates.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: new_value %h improved %b",
							new_value, improved);
				end else begin
					want = pending_updates.pop_front();
					if (new_value !== want.value || improved !== want.better) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: new_value exp %h got %h, improved exp %b got %b",
								want.value, new_value, want.better, improved);
					end
				end
			end
		end
	end

endmodule

/* test/tb_eikonal_8pt_node_update.sv */
`timescale 1ns / 1ps

module tb_eikonal_8pt_node_update;

	localparam logic [31:0] VINF = 32'hFFFF_FFFF;

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic [31:0] cfg_data;
	logic        start;
	logic        busy;
	logic [31:0] nv[8];
	logic [7:0]  neighbor_valid;
	logic [15:0] local_speed;
	logic [31:0] current_value;
	logic        done;
	logic [31:0] new_value;
	logic        improved;
	int          mismatches;
	int          outstanding;
	logic [31:0] spacing_now;
	int          burst_left;

	eikonal_8pt_node_update dut (
		.clk(clk), .arst_n(arst_n), .cfg_write(cfg_write), .cfg_data(cfg_data),
		.start(start), .busy(busy),
		.north_value(nv[0]), .northeast_value(nv[1]), .east_value(nv[2]),
		.southeast_value(nv[3]), .south_value(nv[4]), .southwest_value(nv[5]),
		.west_value(nv[6]), .northwest_value(nv[7]),
		.neighbor_valid(neighbor_valid), .local_speed(local_speed),
		.current_value(current_value),
		.done(done), .new_value(new_value), .improved(improved)
	);

	eik8_node_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_write(cfg_write), .cfg_data(cfg_data),
		.start(start), .busy(busy),
		.north_value(nv[0]), .northeast_value(nv[1]), .east_value(nv[2]),
		.southeast_value(nv[3]), .south_value(nv[4]), .southwest_value(nv[5]),
		.west_value(nv[6]), .northwest_value(nv[7]),
		.neighbor_valid(neighbor_valid), .local_speed(local_speed),
		.current_value(current_value),
		.done(done), .new_value(new_value), .improved(improved),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	initial clk = 0;
	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	initial begin
		#5_000_000;
		$display("** eikonal_8pt_node_update: FAILED **");
		$finish;
	end

	// one item, then a gap when the current burst runs out
	task automatic send_node(input logic [31:0] u[8], input logic [7:0] m,
			input logic [15:0] speed, input logic [31:0] cur);
		nv = u;
		neighbor_valid = m;
		local_speed = speed;
		current_value = cur;
		start = 1;
		do @(posedge clk); while (busy);
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start = 0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 6);
		end
	endtask

	task automatic set_spacing(input logic [31:0] h);
		start = 0;
		while (outstanding != 0) @(negedge clk);
		cfg_write = 1;
		cfg_data = h;
		spacing_now = h;
		@(negedge clk);
		cfg_write = 0;
		cfg_data = $urandom;
	endtask

	task automatic directed_nodes();
		logic [31:0] u[8];
		for (int k = 0; k < 8; k++) u[k] = 32'h0010_0000 + k * 32'h0000_4000;
		send_node(u, 8'h00, 16'h0100, VINF);
		send_node(u, 8'h00, 16'h0100, 32'h0);
		send_node(u, 8'hFF, 16'h0100, VINF);
		send_node(u, 8'h01, 16'h0100, VINF);
		send_node(u, 8'h02, 16'h0100, VINF);
		send_node(u, 8'h03, 16'h0100, 32'h0010_0000);
		send_node(u, 8'h05, 16'h0100, 32'h0);
		send_node(u, 8'h55, 16'h0001, VINF);
		send_node(u, 8'hAA, 16'hFFFF, VINF);
		send_node(u, 8'hFF, 16'hFFFF, VINF);
		send_node(u, 8'hFF, 16'h0000, VINF);
		for (int k = 0; k < 8; k++) u[k] = 32'h0010_0000;
		send_node(u, 8'hFF, 16'hFFFF, VINF);
		send_node(u, 8'hFF, 16'h0100, 32'h0011_0000);
		for (int k = 0; k < 8; k++) u[k] = 32'h0;
		send_node(u, 8'hFF, 16'h0100, VINF);
		for (int k = 0; k < 8; k++) u[k] = VINF;
		send_node(u, 8'hFF, 16'h0100, VINF);
		u[0] = 32'h0002_0000;
		send_node(u, 8'h03, 16'h0100, VINF);
		send_node(u, 8'h05, 16'h0100, VINF);
		u[2] = 32'h0002_8000;
		send_node(u, 8'h07, 16'h0100, VINF);
		u[1] = 32'hFFFF_FFFE;
		send_node(u, 8'h03, 16'h0100, VINF);
		u[2] = 32'h0009_0000;
		send_node(u, 8'h05, 16'h0100, VINF);
	endtask

	task automatic random_nodes(input int count);
		logic [31:0] u[8];
		logic [15:0] speed;
		logic [63:0] sh;
		logic [31:0] base;
		logic [31:0] spread;
		int          mode;
		for (int i = 0; i < count; i++) begin
			mode = $urandom_range(0, 9);
			speed = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 65535))
				: 16'($urandom_range(32, 2048));
			if (mode < 2) begin
				for (int k = 0; k < 8; k++) u[k] = $urandom;
				send_node(u, 8'($urandom), speed, $urandom);
			end else begin
				sh = (64'(spacing_now) << 8) / speed;
				if (sh > 64'hFFFF_FFFF) sh = 64'hFFFF_FFFF;
				spread = (sh > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : sh[31:0];
				base = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h00FF_FFFF);
				for (int k = 0; k < 8; k++) begin
					u[k] = base + (($urandom_range(0, 2) == 0) ? 32'($urandom) % (spread + 1)
						: 32'($urandom) % (spread / 2 + 1));
					if (u[k] < base) u[k] = VINF;
					if ($urandom_range(0, 19) == 0) u[k] = VINF;
				end
				send_node(u, ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom), speed,
					($urandom_range(0, 7) == 0) ? VINF : base + 32'($urandom) % (spread + 1));
			end
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_write = 0;
		cfg_data = 0;
		start = 0;
		for (int k = 0; k < 8; k++) nv[k] = 0;
		neighbor_valid = 0;
		local_speed = 16'h0100;
		current_value = 0;
		spacing_now = 32'd65536;
		burst_left = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);
		directed_nodes();
		random_nodes(280);
		set_spacing(32'd1);
		directed_nodes();
		random_nodes(200);
		set_spacing(32'hFFFF_FFFF);
		directed_nodes();
		random_nodes(280);
		set_spacing(32'h0000_8000);
		random_nodes(280);
		set_spacing($urandom);
		random_nodes(280);
		set_spacing(32'h0001_0000);
		random_nodes(280);
		start = 0;
		while (outstanding != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("** eikonal_8pt_node_update: PASSED **");
		else
			$display("** eikonal_8pt_node_update: FAILED **");
		$finish;
	end

endmodule

/* files.f */
hdl/eik8_pkg.sv
hdl/eik8_div.sv
hdl/eik8_sqrt.sv
hdl/eikonal_8pt_node_update.sv
test/eik8_node_checker.sv
test/tb_eikonal_8pt_node_update.sv
